### rtl/mpts_pkg.sv
// shared types and constants of the memory pattern test sequencer
// no dependencies; imported by every rtl file of the block
package mpts_pkg;

   // register and result field widths
   localparam int REGION_W   = 25;
   localparam int OUT_ADDR_W = 24;
   localparam int WORD_W     = 32;
   localparam int WALK_W     = 5;

   localparam logic [REGION_W-1:0] REGION_RESET = 25'd2097152;

   // pattern constants
   localparam logic [WORD_W-1:0] PRBS_SEED = 32'h1234_5678;
   localparam logic [WORD_W-1:0] CHK_EVEN  = 32'h5555_5555;
   localparam logic [WORD_W-1:0] CHK_ODD   = 32'hAAAA_AAAA;
   localparam int XS_SHL_A = 13;
   localparam int XS_SHR   = 17;
   localparam int XS_SHL_B = 5;

   // input word kinds
   localparam logic KIND_START = 1'b0;
   localparam logic KIND_DONE  = 1'b1;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_PRBS_WR = 3'd1,
      PH_PRBS_RD = 3'd2,
      PH_CHK_WR  = 3'd3,
      PH_CHK_RD  = 3'd4,
      PH_WALK_WR = 3'd5,
      PH_WALK_RD = 3'd6,
      PH_DONE    = 3'd7
   } phase_type;

   typedef enum logic [1:0] {
      ACC_NONE  = 2'd0,
      ACC_WRITE = 2'd1,
      ACC_READ  = 2'd2
   } access_type;

   typedef enum logic [1:0] {
      ST_RUNNING = 2'd0,
      ST_PASSED  = 2'd1,
      ST_FAILED  = 2'd2,
      ST_IDLE    = 2'd3
   } status_type;

   typedef struct packed {
      logic              kind;
      logic [WORD_W-1:0] read_data;
   } req_word_type;

   typedef struct packed {
      access_type            access_kind;
      logic [OUT_ADDR_W-1:0] access_address;
      logic [WORD_W-1:0]     write_data;
      status_type            status;
      logic [OUT_ADDR_W-1:0] fail_offset;
      logic [WORD_W-1:0]     fail_expected;
      logic [WORD_W-1:0]     fail_actual;
   } rsp_word_type;

endpackage

### rtl/mpts_pattern_gen.sv
// pattern word generator: xorshift32, checkerboard and walking one
// depends on mpts_pkg
module mpts_pattern_gen (
   input  mpts_pkg::phase_type   phase,
   input  logic [4:0]            walk_idx,
   input  logic [31:0]           prng_base,
   output logic [31:0]           word,
   output logic [31:0]           prng_adv
);
   import mpts_pkg::*;

   logic [WORD_W-1:0] xs_a;
   logic [WORD_W-1:0] xs_b;
   logic [WORD_W-1:0] xs_c;

   // one xorshift32 step
   assign xs_a = prng_base ^ (prng_base << XS_SHL_A);
   assign xs_b = xs_a ^ (xs_a >> XS_SHR);
   assign xs_c = xs_b ^ (xs_b << XS_SHL_B);

   always_comb begin
      prng_adv = prng_base;
      unique case (phase)
         PH_PRBS_WR, PH_PRBS_RD: begin
            word     = xs_c;
            prng_adv = xs_c;
         end
         PH_CHK_WR, PH_CHK_RD: begin
            word = walk_idx[0] ? CHK_ODD : CHK_EVEN;
         end
         PH_WALK_WR, PH_WALK_RD: begin
            word = {{(WORD_W-1){1'b0}}, 1'b1} << walk_idx;
         end
         default: begin
            word = '0;
         end
      endcase
   end

endmodule

### rtl/mpts_seq_core.sv
// sequencer core: phase state machine, word index, prng and failure capture
// depends on mpts_pkg and mpts_pattern_gen
module mpts_seq_core #(
   parameter int ADDR_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   fire,
   input  mpts_pkg::req_word_type item,
   input  logic [24:0]            region_words,
   output mpts_pkg::rsp_word_type rsp
);
   import mpts_pkg::*;

   localparam int CntW = (ADDR_BITS + 1 > REGION_W) ? ADDR_BITS + 1 : REGION_W;

   phase_type             phase_ff,  phase_in;
   logic                  failed_ff, failed_in;
   logic [ADDR_BITS-1:0]  idx_ff,    idx_in;
   logic [WORD_W-1:0]     prng_ff,   prng_in;
   logic [WORD_W-1:0]     pend_ff,   pend_in;
   logic [ADDR_BITS-1:0]  fo_ff,     fo_in;
   logic [WORD_W-1:0]     fe_ff,     fe_in;
   logic [WORD_W-1:0]     fa_ff,     fa_in;

   logic                  named;
   logic                  use_seed;
   logic                  active;
   logic                  more;
   logic [CntW-1:0]       region_ext;
   logic [CntW-1:0]       lim;
   logic [CntW-1:0]       n_words;
   logic [CntW-1:0]       idx_plus;
   logic [WORD_W-1:0]     gen_word;
   logic [WORD_W-1:0]     gen_prng;
   logic [WORD_W-1:0]     prng_base;
   logic                  rd_new;

   function automatic logic is_read_phase(phase_type p);
      is_read_phase = (p == PH_PRBS_RD) || (p == PH_CHK_RD) || (p == PH_WALK_RD);
   endfunction

   // effective region size, clamped to 1 .. 2^ADDR_BITS
   assign region_ext = CntW'(region_words);
   assign lim        = CntW'(1) << ADDR_BITS;
   assign n_words    = (region_words == '0) ? CntW'(1) :
                       ((region_ext > lim) ? lim : region_ext);
   assign idx_plus   = CntW'(idx_ff) + CntW'(1);
   assign more       = idx_plus < n_words;
   assign active     = (phase_ff != PH_IDLE) && (phase_ff != PH_DONE);

   always_comb begin
      phase_in  = phase_ff;
      idx_in    = idx_ff;
      failed_in = failed_ff;
      fo_in     = fo_ff;
      fe_in     = fe_ff;
      fa_in     = fa_ff;
      named     = 1'b0;
      use_seed  = 1'b0;
      if (fire) begin
         if (item.kind == KIND_START) begin
            failed_in = 1'b0;
            fo_in     = '0;
            fe_in     = '0;
            fa_in     = '0;
            phase_in  = PH_PRBS_WR;
            idx_in    = '0;
            use_seed  = 1'b1;
            named     = 1'b1;
         end else if (active) begin
            if (is_read_phase(phase_ff) && (item.read_data != pend_ff)) begin
               // first mismatch ends the test
               failed_in = 1'b1;
               fo_in     = idx_ff;
               fe_in     = pend_ff;
               fa_in     = item.read_data;
               phase_in  = PH_DONE;
            end else if (more) begin
               idx_in = idx_ff + 1'b1;
               named  = 1'b1;
            end else begin
               unique case (phase_ff)
                  PH_PRBS_WR: begin
                     phase_in = PH_PRBS_RD;
                     idx_in   = '0;
                     use_seed = 1'b1;
                     named    = 1'b1;
                  end
                  PH_PRBS_RD: begin
                     phase_in = PH_CHK_WR;
                     idx_in   = '0;
                     named    = 1'b1;
                  end
                  PH_CHK_WR: begin
                     phase_in = PH_CHK_RD;
                     idx_in   = '0;
                     named    = 1'b1;
                  end
                  PH_CHK_RD: begin
                     phase_in = PH_WALK_WR;
                     idx_in   = '0;
                     named    = 1'b1;
                  end
                  PH_WALK_WR: begin
                     phase_in = PH_WALK_RD;
                     idx_in   = '0;
                     named    = 1'b1;
                  end
                  default: begin
                     phase_in = PH_DONE;
                  end
               endcase
            end
         end
      end
   end

   assign prng_base = use_seed ? PRBS_SEED : prng_ff;

   mpts_pattern_gen u_gen (
      .phase     (phase_in),
      .walk_idx  (WALK_W'(idx_in)),
      .prng_base (prng_base),
      .word      (gen_word),
      .prng_adv  (gen_prng)
   );

   assign prng_in = named ? gen_prng : prng_ff;
   assign pend_in = named ? gen_word : pend_ff;
   assign rd_new  = is_read_phase(phase_in);

   always_comb begin
      rsp.fail_offset   = OUT_ADDR_W'(fo_in);
      rsp.fail_expected = fe_in;
      rsp.fail_actual   = fa_in;
      if (named) begin
         rsp.access_kind    = rd_new ? ACC_READ : ACC_WRITE;
         rsp.access_address = OUT_ADDR_W'(idx_in);
         rsp.write_data     = rd_new ? '0 : gen_word;
         rsp.status         = ST_RUNNING;
      end else begin
         rsp.access_kind    = ACC_NONE;
         rsp.access_address = '0;
         rsp.write_data     = '0;
         rsp.status         = (phase_in == PH_IDLE) ? ST_IDLE :
                              (failed_in ? ST_FAILED : ST_PASSED);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         failed_ff <= 1'b0;
         idx_ff    <= '0;
         prng_ff   <= PRBS_SEED;
         pend_ff   <= '0;
         fo_ff     <= '0;
         fe_ff     <= '0;
         fa_ff     <= '0;
      end else begin
         phase_ff  <= phase_in;
         failed_ff <= failed_in;
         idx_ff    <= idx_in;
         prng_ff   <= prng_in;
         pend_ff   <= pend_in;
         fo_ff     <= fo_in;
         fe_ff     <= fe_in;
         fa_ff     <= fa_in;
      end
   end

endmodule

### rtl/memory_pattern_test_sequencer.sv
// top level of the memory pattern test sequencer: input register, core, result register
// depends on mpts_pkg and mpts_seq_core
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_kind, req_read_data
//   rsp      out        rsp_valid/rsp_stall  access, write data, status, failure capture
//   csr      in         csr_wr_en            csr_wr_data (region_words)
//
// one word per cycle sustained while rsp_stall is low; an accepted word is captured in the
// input register, then the core computes its result and the result register captures it
// once the result register is free, and the result is then valid on rsp
// the path is bounded by the index increment and region compare in the core
// synchronous reset clears the pipeline, the test state and region_words to 2097152
// rsp_stall holds the result register; req_stall rises only while both the input
// register and the result register are full and the result is stalled
module memory_pattern_test_sequencer #(
   parameter int ADDR_BITS = 24
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_kind,
   input  logic [31:0] req_read_data,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_access_kind,
   output logic [23:0] rsp_access_address,
   output logic [31:0] rsp_write_data,
   output logic [1:0]  rsp_status,
   output logic [23:0] rsp_fail_offset,
   output logic [31:0] rsp_fail_expected,
   output logic [31:0] rsp_fail_actual,
   // configuration
   input  logic        csr_wr_en,
   input  logic [24:0] csr_wr_data
);
   import mpts_pkg::*;

   // region size register
   logic [REGION_W-1:0] region_ff;

   // input register stage
   logic          in_valid_ff, in_valid_in;
   req_word_type  item_ff;

   // result register stage
   logic          out_valid_ff, out_valid_in;
   rsp_word_type  rsp_ff;
   rsp_word_type  core_rsp;

   logic          out_free;
   logic          fire;
   logic          accept;

   // the result register can load when empty or being drained this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   // the word in the input register moves through the core into the result register
   assign fire      = in_valid_ff && out_free;
   // input register takes a new word whenever its current one leaves or it is empty
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff    <= REGION_RESET;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            region_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.kind      <= req_kind;
         item_ff.read_data <= req_read_data;
      end
      if (fire) begin
         rsp_ff <= core_rsp;
      end
   end

   // state of the test advances only when a word passes through the core
   mpts_seq_core #(
      .ADDR_BITS (ADDR_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .item         (item_ff),
      .region_words (region_ff),
      .rsp          (core_rsp)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_access_kind    = rsp_ff.access_kind;
   assign rsp_access_address = rsp_ff.access_address;
   assign rsp_write_data     = rsp_ff.write_data;
   assign rsp_status         = rsp_ff.status;
   assign rsp_fail_offset    = rsp_ff.fail_offset;
   assign rsp_fail_expected  = rsp_ff.fail_expected;
   assign rsp_fail_actual    = rsp_ff.fail_actual;

endmodule

### rtl/mpts_checker.sv
// port-level checks of the memory pattern test sequencer, bound to the top level
// depends on mpts_pkg and memory_pattern_test_sequencer
module mpts_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_access_kind,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_write_data,
   input logic [23:0] rsp_fail_offset,
   input logic [31:0] rsp_fail_expected,
   input logic [31:0] rsp_fail_actual
);
   import mpts_pkg::*;

   // an access is named exactly while the test runs
   a_access_running: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_access_kind != ACC_NONE) |-> rsp_status == ST_RUNNING)
      else $error("access named while not running");

   a_running_access: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_RUNNING) |-> rsp_access_kind != ACC_NONE)
      else $error("running without a named access");

   // a passed test carries an empty failure capture
   a_pass_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_PASSED) |->
         (rsp_fail_offset == '0) && (rsp_fail_expected == '0) && (rsp_fail_actual == '0))
      else $error("failure capture set on a passed test");

   // a failure capture always records a real mismatch
   a_fail_mismatch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FAILED) |-> rsp_fail_expected != rsp_fail_actual)
      else $error("failure captured without a mismatch");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_write_data)
         && $stable(rsp_status) && $stable(rsp_access_kind))
      else $error("stalled response word changed");

endmodule

bind memory_pattern_test_sequencer mpts_checker u_mpts_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_access_kind   (rsp_access_kind),
   .rsp_status        (rsp_status),
   .rsp_write_data    (rsp_write_data),
   .rsp_fail_offset   (rsp_fail_offset),
   .rsp_fail_expected (rsp_fail_expected),
   .rsp_fail_actual   (rsp_fail_actual)
);

### tb/memory_pattern_test_sequencer_tb.sv
// testbench of memory_pattern_test_sequencer: drives start and done words, acts as the memory
// and checks every response word against an in-bench model of the three-pattern test
// depends on mpts_pkg and the rtl of memory_pattern_test_sequencer
`timescale 1ns / 1ps

module memory_pattern_test_sequencer_tb;
   import mpts_pkg::*;

   localparam int ADDR_BITS   = 24;
   localparam int QUIET_LIMIT = 5000;   // cycles without any handshake before giving up
   localparam int HOLD_CYCLES = 400;    // length of the long response hold-off

   // tracks the sequencer state and the response words still owed by the block
   class mpts_scoreboard;
      logic [REGION_W-1:0]   region_words;
      phase_type             phase;
      bit                    failed;
      logic [ADDR_BITS-1:0]  word_index;
      logic [WORD_W-1:0]     prng_state;
      logic [WORD_W-1:0]     pending_word;
      logic [OUT_ADDR_W-1:0] capt_offset;
      logic [WORD_W-1:0]     capt_expected;
      logic [WORD_W-1:0]     capt_actual;
      rsp_word_type          expected_rsp[$];
      int                    errors;

      function new();
         region_words  = REGION_RESET;
         phase         = PH_IDLE;
         failed        = 1'b0;
         word_index    = '0;
         prng_state    = PRBS_SEED;
         pending_word  = '0;
         capt_offset   = '0;
         capt_expected = '0;
         capt_actual   = '0;
         errors        = 0;
      endfunction

      function void enter_phase(phase_type p);
         phase      = p;
         word_index = '0;
         if (p == PH_PRBS_WR || p == PH_PRBS_RD) prng_state = PRBS_SEED;
      endfunction

      // pattern word of the current pass at the current index
      function void name_word();
         case (phase)
            PH_PRBS_WR, PH_PRBS_RD: begin
               prng_state   = prng_state ^ (prng_state << XS_SHL_A);
               prng_state   = prng_state ^ (prng_state >> XS_SHR);
               prng_state   = prng_state ^ (prng_state << XS_SHL_B);
               pending_word = prng_state;
            end
            PH_CHK_WR, PH_CHK_RD: pending_word = word_index[0] ? CHK_ODD : CHK_EVEN;
            default: pending_word = 32'd1 << word_index[WALK_W-1:0];
         endcase
      endfunction

      // one accepted request word: advance the model and queue the response it causes
      function void note_request(logic kind, logic [WORD_W-1:0] rd);
         int unsigned  n;
         bit           named;
         bit           is_read;
         rsp_word_type r;
         n = 32'(region_words);
         if (n == 0) n = 1;
         if (n > (32'd1 << ADDR_BITS)) n = 32'd1 << ADDR_BITS;
         named = 1'b0;
         if (kind == KIND_START) begin
            failed        = 1'b0;
            capt_offset   = '0;
            capt_expected = '0;
            capt_actual   = '0;
            enter_phase(PH_PRBS_WR);
            name_word();
            named = 1'b1;
         end else if (phase >= PH_PRBS_WR && phase <= PH_WALK_RD) begin
            is_read = !phase[0];
            if (is_read && rd != pending_word) begin
               failed        = 1'b1;
               capt_offset   = word_index;
               capt_expected = pending_word;
               capt_actual   = rd;
               phase         = PH_DONE;
            end else if (32'(word_index) + 32'd1 < n) begin
               word_index = word_index + 1'b1;
               name_word();
               named = 1'b1;
            end else if (phase == PH_WALK_RD) begin
               phase = PH_DONE;
            end else begin
               enter_phase(phase_type'(phase + 3'd1));
               name_word();
               named = 1'b1;
            end
         end
         if (named) begin
            is_read          = !phase[0];
            r.access_kind    = is_read ? ACC_READ : ACC_WRITE;
            r.access_address = word_index;
            r.write_data     = is_read ? '0 : pending_word;
            r.status         = ST_RUNNING;
         end else begin
            r.access_kind    = ACC_NONE;
            r.access_address = '0;
            r.write_data     = '0;
            r.status         = (phase == PH_IDLE) ? ST_IDLE : (failed ? ST_FAILED : ST_PASSED);
         end
         r.fail_offset   = capt_offset;
         r.fail_expected = capt_expected;
         r.fail_actual   = capt_actual;
         expected_rsp.push_back(r);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %0h actual %0h", name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [1:0] kind, logic [23:0] addr, logic [31:0] wdata,
                                   logic [1:0] status, logic [23:0] offset,
                                   logic [31:0] fexp, logic [31:0] fact);
         rsp_word_type e;
         if (expected_rsp.size() == 0) begin
            $error("response word with no request behind it");
            errors++;
         end else begin
            e = expected_rsp.pop_front();
            compare_field("access_kind", e.access_kind, kind);
            compare_field("access_address", e.access_address, addr);
            compare_field("write_data", e.write_data, wdata);
            compare_field("status", e.status, status);
            compare_field("fail_offset", e.fail_offset, offset);
            compare_field("fail_expected", e.fail_expected, fexp);
            compare_field("fail_actual", e.fail_actual, fact);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_kind;
   logic [31:0] req_read_data;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [1:0]  rsp_access_kind;
   logic [23:0] rsp_access_address;
   logic [31:0] rsp_write_data;
   logic [1:0]  rsp_status;
   logic [23:0] rsp_fail_offset;
   logic [31:0] rsp_fail_expected;
   logic [31:0] rsp_fail_actual;
   logic        csr_wr_en;
   logic [24:0] csr_wr_data;

   mpts_scoreboard sb;
   int unsigned    send_idle_pct = 0;   // chance per cycle that the request side idles
   int unsigned    rsp_stall_pct = 0;   // chance per cycle that the response side stalls
   int unsigned    sent_count    = 0;   // request words accepted so far
   int unsigned    holds_asked   = 0;   // long hold-offs requested by the stimulus
   int unsigned    holds_served  = 0;   // long hold-offs started by the response side

   always #6 clock = ~clock;

   memory_pattern_test_sequencer #(.ADDR_BITS(ADDR_BITS)) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_read_data      (req_read_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_access_kind    (rsp_access_kind),
      .rsp_access_address (rsp_access_address),
      .rsp_write_data     (rsp_write_data),
      .rsp_status         (rsp_status),
      .rsp_fail_offset    (rsp_fail_offset),
      .rsp_fail_expected  (rsp_fail_expected),
      .rsp_fail_actual    (rsp_fail_actual),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   // offer one request word after a random idle gap, return once it is accepted
   // the model is advanced right here, so the next word can depend on its state
   task automatic send_word(input logic kind, input logic [31:0] data);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_kind      <= kind;
      req_read_data <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_request(kind, data);
      sent_count++;
   endtask

   // stop offering and wait until every owed response word has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_rsp.size() != 0) @(posedge clock);
   endtask

   // region size is only changed with nothing in flight; the extra wait before the write
   // covers the two-stage pipeline in case the last word is still being registered
   task automatic set_region(input logic [24:0] words);
      drain();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= words;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      sb.region_words = words;
   endtask

   // play the memory for the running test: random data on writes, the pattern word on
   // reads, now and then a corrupted read or a restart in the middle of the test
   task automatic run_pattern_test(input int unsigned flip_permille,
                                   input int unsigned restart_permille,
                                   input int unsigned max_words);
      int unsigned count;
      count = 0;
      while (sb.phase != PH_DONE && count < max_words) begin
         if ($urandom_range(999) < restart_permille) begin
            send_word(KIND_START, $urandom);
         end else if (!sb.phase[0] && $urandom_range(999) < flip_permille) begin
            // single flipped bit or a wholly random word
            if ($urandom_range(1))
               send_word(KIND_DONE, sb.pending_word ^ (32'd1 << $urandom_range(31)));
            else
               send_word(KIND_DONE, $urandom);
         end else begin
            send_word(KIND_DONE, sb.phase[0] ? $urandom : sb.pending_word);
         end
         count++;
      end
   endtask

   // response side: check accepted words, stall at random or hold off for a long stretch
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_response(rsp_access_kind, rsp_access_address, rsp_write_data,
                              rsp_status, rsp_fail_offset, rsp_fail_expected,
                              rsp_fail_actual);
         if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
         end
      end
   end

   // watchdog: too long without any word moving on either channel
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("[memory_pattern_test_sequencer] ERROR");
            $finish;
         end
      end
   end

   initial begin : stimulus
      int unsigned phase_sel;
      int unsigned phase_start;
      int unsigned pick;
      logic [24:0] words;
      sb = new();
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_kind      <= KIND_DONE;
      req_read_data <= '0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // done words while idle are ignored and report idle
      send_word(KIND_DONE, 32'h0000_0000);
      send_word(KIND_DONE, 32'hFFFF_FFFF);
      // start under the reset region size, a few prbs writes
      send_word(KIND_START, 32'hFFFF_FFFF);
      repeat (4) send_word(KIND_DONE, $urandom);
      // region shrunk below the current index mid-test: the write pass ends at once
      set_region(25'd3);
      run_pattern_test(0, 0, 100);
      // done word after a passed test keeps the status
      send_word(KIND_DONE, $urandom);

      // region of zero saturates to one word; corrupt the first read
      set_region(25'd0);
      send_word(KIND_START, $urandom);
      run_pattern_test(1000, 0, 100);
      send_word(KIND_DONE, $urandom);
      // a new start clears the failure capture
      send_word(KIND_START, $urandom);
      run_pattern_test(0, 0, 100);

      // oversized region saturates to the full address space, then the exact maximum
      set_region(25'h1FF_FFFF);
      send_word(KIND_START, $urandom);
      run_pattern_test(0, 0, 30);
      set_region(25'h100_0000);
      run_pattern_test(0, 0, 10);
      send_word(KIND_START, $urandom);
      run_pattern_test(0, 0, 10);
      // shrinking the region ends the pass and the test runs out normally
      set_region(25'd2);
      run_pattern_test(0, 0, 100);

      // random part: four idling mixes, mostly small regions, some past 32 words so the
      // walking one wraps around
      for (phase_sel = 0; phase_sel < 4; phase_sel++) begin
         case (phase_sel)
            0: begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin send_idle_pct = 59; rsp_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct = 59; end
            default: begin send_idle_pct = 18; rsp_stall_pct = 18; end
         endcase
         if (phase_sel == 2) begin
            // long hold on responses while requests keep coming: the block fills up
            set_region(25'd40);
            holds_asked++;
            send_word(KIND_START, $urandom);
            run_pattern_test(0, 0, 300);
         end
         phase_start = sent_count;
         while (sent_count - phase_start < 280) begin
            pick = $urandom_range(99);
            if (pick < 80) words = 25'($urandom_range(8, 1));
            else if (pick < 95) words = 25'($urandom_range(40, 9));
            else words = 25'($urandom_range(70, 33));
            set_region(words);
            send_word(KIND_START, $urandom);
            run_pattern_test(15, 3, 5000);
            // stray done word after the test has finished
            if ($urandom_range(3) == 0) send_word(KIND_DONE, $urandom);
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (sb.errors == 0) begin
         $display("[memory_pattern_test_sequencer] OK");
      end else begin
         $display("[memory_pattern_test_sequencer] ERROR");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/mpts_pkg.sv
rtl/mpts_pattern_gen.sv
rtl/mpts_seq_core.sv
rtl/memory_pattern_test_sequencer.sv
rtl/mpts_checker.sv
tb/memory_pattern_test_sequencer_tb.sv
